### rtl/core/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration token checker package
// Shared types, character codes and event codes of the token syntax checker.
// ----------------------------------------------------------------------------
package cts_pkg;

  // input operation codes
  localparam logic OpText = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // result event codes
  localparam logic [1:0] EvValue  = 2'd0;
  localparam logic [1:0] EvDone   = 2'd1;
  localparam logic [1:0] EvAccept = 2'd2;
  localparam logic [1:0] EvReject = 2'd3;

  // token kinds reported on a completed token
  localparam logic [2:0] KindWord  = 3'd0;
  localparam logic [2:0] KindOpen  = 3'd1;
  localparam logic [2:0] KindClose = 3'd2;
  localparam logic [2:0] KindSemi  = 3'd3;
  localparam logic [2:0] KindCmt   = 3'd4;

  // characters with a meaning to the lexer
  localparam logic [7:0] ChOpen   = 8'h7B;
  localparam logic [7:0] ChClose  = 8'h7D;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;

  // results one input beat can cause, and the queue between front and back
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;

  // lexer mode, one-hot
  typedef enum logic [4:0] {
    ModeIdle = 5'b00001,
    ModeWord = 5'b00010,
    ModeSq   = 5'b00100,
    ModeDq   = 5'b01000,
    ModeCmt  = 5'b10000
  } mode_e;

  // last grammar token seen
  typedef enum logic [2:0] {
    PrevStart = 3'd0,
    PrevWord  = 3'd1,
    PrevOpen  = 3'd2,
    PrevClose = 3'd3,
    PrevSemi  = 3'd4
  } prev_e;

  // one result without its last flag
  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] value_byte;
    logic [2:0] token_kind;
    logic       new_statement;
    logic [3:0] depth;
  } result_t;

  // all results of one input beat
  typedef struct packed {
    logic [1:0]           cnt;
    result_t [MaxRes-1:0] res;
  } bundle_t;

  function automatic result_t mk_res(logic [1:0] ev, logic [7:0] vb, logic [2:0] kind,
                                     logic ns, logic [3:0] dep);
    result_t r;
    r.event_res     = ev;
    r.value_byte    = vb;
    r.token_kind    = kind;
    r.new_statement = ns;
    r.depth         = dep;
    return r;
  endfunction

endpackage

### rtl/core/cts_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text input channel
// Valid/ready channel carrying one text byte or an end-of-input mark.
// ----------------------------------------------------------------------------
interface cts_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] text_byte;

  modport source (output valid, output op, output text_byte, input ready);
  modport sink (input valid, input op, input text_byte, output ready);
endinterface

### rtl/core/cts_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one token event per beat.
// ----------------------------------------------------------------------------
interface cts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] value_byte;
  logic [2:0] token_kind;
  logic       new_statement;
  logic [3:0] depth;
  logic       last;

  modport source (output valid, output event_res, output value_byte, output token_kind,
                  output new_statement, output depth, output last, input ready);
  modport sink (input valid, input event_res, input value_byte, input token_kind,
                input new_statement, input depth, input last, output ready);
endinterface

### rtl/core/config_token_syntax_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration token syntax checker
// Tokenizes a block-structured configuration text and checks its grammar.
// ----------------------------------------------------------------------------
// The block takes one text byte or end-of-input mark per beat and answers
// with up to three result beats: value bytes, token-completed events and a
// final accept or reject verdict, the last one of each input beat flagged by
// last. The lexer front end takes a new byte every cycle as long as its
// four-entry bundle queue has room; the back end sends one result per cycle
// from an output register while the receiver is ready, so the sustained
// input rate is one byte per cycle, falling to one byte per result where
// bytes cause two or three results. A byte's results reach the output
// through the bundle queue and then the output register. Whitespace between
// tokens, ignored bytes after a failure, and rejected tokens give no result.
// ----------------------------------------------------------------------------
module config_token_syntax_checker_top #(
  parameter int unsigned MAX_DEPTH = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cts_in_if.sink    in_i,
  cts_out_if.source out_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             nonempty;
  cts_pkg::bundle_t bundle;
  cts_pkg::bundle_t head;

  // lexer and grammar check
  cts_front #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .bundle_o(bundle)
  );

  // bundle queue
  cts_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .bundle_i  (bundle),
    .full_o    (full),
    .pop_i     (pop),
    .nonempty_o(nonempty),
    .head_o    (head)
  );

  // result sequencing
  cts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .nonempty_i(nonempty),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

### rtl/core/cts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token checker front end
// Lexes one byte per beat, checks token order and nesting, and builds the
// bundle of results the byte causes.
// ----------------------------------------------------------------------------
module cts_front #(
  parameter int unsigned MAX_DEPTH = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cts_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output cts_pkg::bundle_t bundle_o
);

  localparam logic [3:0] DepthLimit = (MAX_DEPTH < 15) ? 4'(MAX_DEPTH) : 4'd15;

  cts_pkg::mode_e mode_q, mode_d;
  cts_pkg::prev_e prev_q, prev_d;
  logic [3:0]     depth_q, depth_d;
  logic           failed_q, failed_d;

  logic [1:0]       n;
  cts_pkg::result_t res [cts_pkg::MaxRes];
  logic             do_between;
  logic             ok;
  logic             accept;
  logic [7:0]       c;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign c          = in_i.text_byte;

  // next lexer state and results of this beat
  always_comb begin
    mode_d     = mode_q;
    prev_d     = prev_q;
    depth_d    = depth_q;
    failed_d   = failed_q;
    n          = 2'd0;
    do_between = 1'b0;
    ok         = 1'b0;
    for (int i = 0; i < cts_pkg::MaxRes; i++) begin
      res[i] = '0;
    end

    if (in_i.op == cts_pkg::OpText) begin
      if (!failed_q) begin
        unique case (mode_q)
          cts_pkg::ModeWord: begin
            if (c == cts_pkg::ChSpace || c == cts_pkg::ChTab || c == cts_pkg::ChNl ||
                c == cts_pkg::ChCr || c == cts_pkg::ChSemi || c == cts_pkg::ChOpen ||
                c == cts_pkg::ChClose) begin
              // delimiter ends the word, then acts between tokens
              res[n]     = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindWord,
                                           prev_d != cts_pkg::PrevWord, depth_d);
              n          = n + 2'd1;
              prev_d     = cts_pkg::PrevWord;
              mode_d     = cts_pkg::ModeIdle;
              do_between = 1'b1;
            end else begin
              res[n] = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0, depth_d);
              n      = n + 2'd1;
            end
          end
          cts_pkg::ModeSq, cts_pkg::ModeDq: begin
            res[n] = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0, depth_d);
            n      = n + 2'd1;
            if ((mode_q == cts_pkg::ModeSq && c == cts_pkg::ChSquote) ||
                (mode_q == cts_pkg::ModeDq && c == cts_pkg::ChDquote)) begin
              res[n] = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindWord,
                                       prev_d != cts_pkg::PrevWord, depth_d);
              n      = n + 2'd1;
              prev_d = cts_pkg::PrevWord;
              mode_d = cts_pkg::ModeIdle;
            end
          end
          cts_pkg::ModeCmt: begin
            if (c == cts_pkg::ChNl || c == cts_pkg::ChCr) begin
              mode_d = cts_pkg::ModeIdle;
              res[n] = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindCmt, 1'b0, depth_d);
              n      = n + 2'd1;
            end else begin
              res[n] = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0, depth_d);
              n      = n + 2'd1;
            end
          end
          default: begin
            mode_d     = cts_pkg::ModeIdle;
            do_between = 1'b1;
          end
        endcase

        // byte handled between tokens
        if (do_between) begin
          unique case (c) inside
            cts_pkg::ChOpen: begin
              if (prev_d != cts_pkg::PrevWord || depth_d >= DepthLimit) begin
                failed_d = 1'b1;
              end else begin
                res[n]  = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0,
                                          depth_d);
                n       = n + 2'd1;
                depth_d = depth_d + 4'd1;
                res[n]  = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindOpen, 1'b0,
                                          depth_d);
                n       = n + 2'd1;
                prev_d  = cts_pkg::PrevOpen;
              end
            end
            cts_pkg::ChClose: begin
              if ((prev_d != cts_pkg::PrevSemi && prev_d != cts_pkg::PrevOpen &&
                   prev_d != cts_pkg::PrevClose) || depth_d == 4'd0) begin
                failed_d = 1'b1;
              end else begin
                res[n]  = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0,
                                          depth_d);
                n       = n + 2'd1;
                depth_d = depth_d - 4'd1;
                res[n]  = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindClose, 1'b0,
                                          depth_d);
                n       = n + 2'd1;
                prev_d  = cts_pkg::PrevClose;
              end
            end
            cts_pkg::ChSemi: begin
              if (prev_d != cts_pkg::PrevWord) begin
                failed_d = 1'b1;
              end else begin
                res[n] = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0,
                                         depth_d);
                n      = n + 2'd1;
                res[n] = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindSemi, 1'b0,
                                         depth_d);
                n      = n + 2'd1;
                prev_d = cts_pkg::PrevSemi;
              end
            end
            cts_pkg::ChHash, cts_pkg::ChDquote, cts_pkg::ChSquote: begin
              if (c == cts_pkg::ChHash) begin
                mode_d = cts_pkg::ModeCmt;
              end else if (c == cts_pkg::ChDquote) begin
                mode_d = cts_pkg::ModeDq;
              end else begin
                mode_d = cts_pkg::ModeSq;
              end
              res[n] = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0, depth_d);
              n      = n + 2'd1;
            end
            cts_pkg::ChSpace, cts_pkg::ChTab, cts_pkg::ChNl, cts_pkg::ChCr: begin
              mode_d = cts_pkg::ModeIdle;
            end
            default: begin
              mode_d = cts_pkg::ModeWord;
              res[n] = cts_pkg::mk_res(cts_pkg::EvValue, c, cts_pkg::KindWord, 1'b0, depth_d);
              n      = n + 2'd1;
            end
          endcase
        end
      end
    end else begin
      // end of input: close an open word or comment, then give the verdict
      if (!failed_q) begin
        if (mode_q == cts_pkg::ModeWord) begin
          res[n] = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindWord,
                                   prev_d != cts_pkg::PrevWord, depth_d);
          n      = n + 2'd1;
          prev_d = cts_pkg::PrevWord;
        end else if (mode_q == cts_pkg::ModeCmt) begin
          res[n] = cts_pkg::mk_res(cts_pkg::EvDone, 8'd0, cts_pkg::KindCmt, 1'b0, depth_d);
          n      = n + 2'd1;
        end else if (mode_q == cts_pkg::ModeSq || mode_q == cts_pkg::ModeDq) begin
          failed_d = 1'b1;
        end
      end
      ok = !failed_d && depth_d == 4'd0 &&
           (prev_d == cts_pkg::PrevSemi || prev_d == cts_pkg::PrevClose);
      res[n]   = cts_pkg::mk_res(ok ? cts_pkg::EvAccept : cts_pkg::EvReject, 8'd0,
                                 cts_pkg::KindWord, 1'b0, 4'd0);
      n        = n + 2'd1;
      mode_d   = cts_pkg::ModeIdle;
      prev_d   = cts_pkg::PrevStart;
      depth_d  = 4'd0;
      failed_d = 1'b0;
    end
  end

  // bundle toward the queue; beats with no result push nothing
  always_comb begin
    bundle_o.cnt = n;
    for (int i = 0; i < cts_pkg::MaxRes; i++) begin
      bundle_o.res[i] = res[i];
    end
  end
  assign push_o = accept && (n != 2'd0);

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= cts_pkg::ModeIdle;
      prev_q   <= cts_pkg::PrevStart;
      depth_q  <= 4'd0;
      failed_q <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      prev_q   <= prev_d;
      depth_q  <= depth_d;
      failed_q <= failed_d;
    end
  end

endmodule

### rtl/core/cts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token checker bundle queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module cts_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cts_pkg::bundle_t bundle_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             nonempty_o,
  output cts_pkg::bundle_t head_o
);

  cts_pkg::bundle_t             mem_q [cts_pkg::QDepth];
  logic [cts_pkg::QPtrW-1:0]    wptr_q, rptr_q;
  logic [cts_pkg::QPtrW:0]      count_q;
  logic                         do_pop;

  assign full_o     = count_q == (cts_pkg::QPtrW + 1)'(cts_pkg::QDepth);
  assign nonempty_o = count_q != '0;
  assign head_o     = mem_q[rptr_q];
  assign do_pop     = pop_i && nonempty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= bundle_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/cts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token checker back end
// Unpacks queued bundles into single result beats behind an output register.
// ----------------------------------------------------------------------------
module cts_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             nonempty_i,
  input  cts_pkg::bundle_t head_i,
  output logic             pop_o,
  cts_out_if.source        out_o
);

  logic [1:0]       idx_q;
  logic             valid_q;
  cts_pkg::result_t res_q;
  logic             last_q;
  logic             load;
  logic             is_last;
  cts_pkg::result_t sel;

  assign load    = nonempty_i && (!valid_q || out_o.ready);
  assign sel     = head_i.res[idx_q];
  assign is_last = idx_q == (head_i.cnt - 2'd1);
  assign pop_o   = load && is_last;

  // result index within the head bundle and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= sel;
      last_q <= is_last;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.event_res     = res_q.event_res;
  assign out_o.value_byte    = res_q.value_byte;
  assign out_o.token_kind    = res_q.token_kind;
  assign out_o.new_statement = res_q.new_statement;
  assign out_o.depth         = res_q.depth;
  assign out_o.last          = last_q;

endmodule
